FILE: rtl/core/aesd_pkg.sv
// Shared types, constants and byte functions for the AES block decryption unit.
`timescale 1ns / 1ps
`default_nettype none
package aesd_pkg;

    // One ciphertext item on the input channel.
    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } in_t;

    // One plaintext item on the result channel.
    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } out_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

    // Round kinds handled by the shared round unit.
    localparam logic [1:0] RND_FIRST  = 2'd0;
    localparam logic [1:0] RND_MIDDLE = 2'd1;
    localparam logic [1:0] RND_LAST   = 2'd2;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward S-box on each byte of a word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // InvMixColumns on one column, byte 0 in the top bits.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2, x4, x8;
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8*k -: 8];
            x2    = xtime(a[k]);
            x4    = xtime(x2);
            x8    = xtime(x4);
            m9[k] = x8 ^ a[k];
            mb[k] = x8 ^ x2 ^ a[k];
            md[k] = x8 ^ x4 ^ a[k];
            me[k] = x8 ^ x4 ^ x2;
        end
        inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                       m9[0] ^ me[1] ^ mb[2] ^ md[3],
                       md[0] ^ m9[1] ^ me[2] ^ mb[3],
                       mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/aesd_ram.sv
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module aesd_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/aesd_keyexp.sv
// Key expansion sequencer: one schedule word per cycle, a row of four words per write.
`timescale 1ns / 1ps
`default_nettype none
module aesd_keyexp
    import aesd_pkg::*;
#(
    parameter int MAX_ROUNDS = 14
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [1:0]                            sel,
    input  wire logic [3:0][63:0]                      key_words,
    output logic                                       wr_en,
    output logic      [$clog2(MAX_ROUNDS+1)-1:0]       wr_row,
    output logic      [127:0]                          wr_data,
    output logic                                       done
);

    localparam int WordW = $clog2(4 * (MAX_ROUNDS + 1));

    logic             busy_reg;
    logic [WordW-1:0] cnt_reg;
    logic [2:0]       mod_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      win_reg [8];

    logic [3:0]       nk;
    logic [WordW-1:0] last;
    logic [2:0]       nk_m1;
    logic [63:0]      kw;
    logic [31:0]      t;
    logic [31:0]      word;
    logic             use_key;

    // Key length in words and index of the last schedule word.
    assign nk    = 4'd4 + {1'b0, sel, 1'b0};
    assign nk_m1 = nk[2:0] - 3'd1;
    assign last  = WordW'(4 * (nk + 4'd7) - 1);
    assign use_key = cnt_reg < WordW'(nk);

    // Next schedule word from the window of earlier words.
    always_comb begin
        kw = key_words[cnt_reg[2:1]];
        t  = win_reg[0];
        if (mod_reg == 3'd0) begin
            t = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t = sub_word(win_reg[0]);
        end
        if (use_key) begin
            word = cnt_reg[0] ? kw[31:0] : kw[63:32];
        end else begin
            word = win_reg[nk_m1] ^ t;
        end
    end

    assign wr_en   = busy_reg && (cnt_reg[1:0] == 2'd3);
    assign wr_row  = cnt_reg[WordW-1:2];
    assign wr_data = {win_reg[2], win_reg[1], win_reg[0], word};
    assign done    = busy_reg && (cnt_reg == last);

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            if (done) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
            mod_reg <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (!use_key && mod_reg == 3'd0) begin
                rcon_reg <= xtime(rcon_reg);
            end
        end
    end

    // Window of the most recent eight words.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/aesd_round.sv
// Shared inverse round unit: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
`timescale 1ns / 1ps
`default_nettype none
module aesd_round
    import aesd_pkg::*;
(
    input  wire logic [127:0] state_in,
    input  wire logic [127:0] round_key,
    input  wire logic [1:0]   kind,
    output logic      [127:0] state_out
);

    logic [127:0] shifted;
    logic [127:0] keyed;
    logic [127:0] mixed;

    // Byte 4c+r moves to column (c+r) mod 4 through the inverse S-box.
    always_comb begin
        shifted = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[127 - 8*(4*((c + r) % 4) + r) -: 8] =
                    INV_SBOX[state_in[127 - 8*(4*c + r) -: 8]];
            end
        end
    end

    assign keyed = shifted ^ round_key;

    // Column mixing on the keyed state.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mixed[127 - 32*c -: 32] = inv_mix_col(keyed[127 - 32*c -: 32]);
        end
    end

    // Select by round kind.
    always_comb begin
        unique case (kind)
            RND_FIRST:  state_out = state_in ^ round_key;
            RND_MIDDLE: state_out = mixed;
            RND_LAST:   state_out = keyed;
            default:    state_out = keyed;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/aes_block_decrypt_unit.sv
// Top level of the AES block decryption unit: registers, sequencer and output stage.
//
//  Port group   Direction  Handshake           Payload
//  cfg_*        in         cfg_we only         cfg_index, cfg_wdata
//  s_*          in         s_valid / s_ready   s_payload (cipher_high, cipher_low)
//  m_*          out        m_valid / m_ready   m_payload (plain_high, plain_low)
//
// After an item is accepted (Nr = 10, 12 or 14), the PRE state prefetches the last
// round-key row; then each RUN step reads one row from the round-key RAM and runs one
// round through the shared round unit, Nr + 1 rounds in all. A new item is accepted only
// after the final round, once the unit is back in IDLE, so items do not overlap.
// The first item after reset or a write to the key size or a key word register first
// runs the key expansion at one schedule word per cycle.
// Reset clears the control state and the key registers and marks the schedule stale.
// A result waiting at the output does not block the next item; the final round stalls
// only while that result is still untaken.
`timescale 1ns / 1ps
`default_nettype none
module aes_block_decrypt_unit
    import aesd_pkg::*;
#(
    parameter int MAX_ROUNDS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_payload
);

    localparam int RowW   = $clog2(MAX_ROUNDS + 1);
    localparam int SelMax = (MAX_ROUNDS - 10) / 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_PRE  = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]       fsm_reg;
    logic [1:0]       key_size_reg;
    logic [3:0][63:0] key_words_reg;
    logic             sched_ok_reg;
    logic [RowW-1:0]  rnd_reg;
    logic [127:0]     st_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic [1:0]      sel_raw;
    logic [1:0]      sel;
    logic [RowW-1:0] nr;
    logic            exp_start;
    logic            exp_wr_en;
    logic [RowW-1:0] exp_wr_row;
    logic [127:0]    exp_wr_data;
    logic            exp_done;
    logic [RowW-1:0] rd_row;
    logic [127:0]    rk_row;
    logic [1:0]      kind;
    logic [127:0]    rnd_out;
    logic            slot_free;
    logic            s_fire;

    // Key size with size three as 256 and a fallback to what fits.
    assign sel_raw = (key_size_reg == 2'd3) ? 2'd2 : key_size_reg;
    assign sel     = (sel_raw > 2'(SelMax)) ? 2'(SelMax) : sel_raw;
    assign nr      = RowW'(10 + 2 * sel);

    assign s_ready   = (fsm_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign exp_start = s_fire && !sched_ok_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg  <= '0;
            key_words_reg <= '0;
            sched_ok_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY_SIZE: begin
                        key_size_reg <= cfg_wdata[1:0];
                        sched_ok_reg <= 1'b0;
                    end
                    CFG_KEY_WORD_0: begin
                        key_words_reg[0] <= cfg_wdata;
                        sched_ok_reg     <= 1'b0;
                    end
                    CFG_KEY_WORD_1: begin
                        key_words_reg[1] <= cfg_wdata;
                        sched_ok_reg     <= 1'b0;
                    end
                    CFG_KEY_WORD_2: begin
                        key_words_reg[2] <= cfg_wdata;
                        sched_ok_reg     <= 1'b0;
                    end
                    CFG_KEY_WORD_3: begin
                        key_words_reg[3] <= cfg_wdata;
                        sched_ok_reg     <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (exp_done) begin
                sched_ok_reg <= 1'b1;
            end
        end
    end

    aesd_keyexp #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) u_keyexp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (exp_start),
        .sel      (sel),
        .key_words(key_words_reg),
        .wr_en    (exp_wr_en),
        .wr_row   (exp_wr_row),
        .wr_data  (exp_wr_data),
        .done     (exp_done)
    );

    // Row address for the registered RAM read, set in the cycle before the round that uses it.
    always_comb begin
        if (fsm_reg == ST_RUN) begin
            rd_row = (rnd_reg == '0) ? '0 : rnd_reg - 1'b1;
        end else begin
            rd_row = nr;
        end
    end

    aesd_ram #(
        .WIDTH(128),
        .DEPTH(MAX_ROUNDS + 1)
    ) u_rk_ram (
        .aclk (aclk),
        .we   (exp_wr_en),
        .waddr(exp_wr_row),
        .wdata(exp_wr_data),
        .raddr(rd_row),
        .rdata(rk_row)
    );

    // Round kind from the round counter.
    always_comb begin
        if (rnd_reg == nr) begin
            kind = RND_FIRST;
        end else if (rnd_reg == '0) begin
            kind = RND_LAST;
        end else begin
            kind = RND_MIDDLE;
        end
    end

    aesd_round u_round (
        .state_in (st_reg),
        .round_key(rk_row),
        .kind     (kind),
        .state_out(rnd_out)
    );

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= ST_IDLE;
            rnd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(fsm_reg == ST_RUN && rnd_reg == '0)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        fsm_reg <= sched_ok_reg ? ST_PRE : ST_EXP;
                    end
                end
                ST_EXP: begin
                    if (exp_done) begin
                        fsm_reg <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    rnd_reg <= nr;
                    fsm_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (rnd_reg != '0) begin
                        rnd_reg <= rnd_reg - 1'b1;
                    end else if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        fsm_reg     <= ST_IDLE;
                    end else if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                default: fsm_reg <= ST_IDLE;
            endcase
        end
    end

    // Working state and output data.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_reg <= {s_payload.cipher_high, s_payload.cipher_low};
        end else if (fsm_reg == ST_RUN && rnd_reg != '0) begin
            st_reg <= rnd_out;
        end
        if (fsm_reg == ST_RUN && rnd_reg == '0 && slot_free) begin
            m_data_reg.plain_high <= rnd_out[127:64];
            m_data_reg.plain_low  <= rnd_out[63:0];
        end
    end

endmodule
`default_nettype wire

FILE: dv/aes_block_decrypt_unit_test.sv
// Self-checking testbench for the AES block decryption unit with its own decryption predictor.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected plaintexts in order and counts mismatches.
class plaintext_scoreboard;
    aesd_pkg::out_t pending_plain[$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
    endfunction

    // Notes the plaintext that an accepted ciphertext item must produce.
    function void note_cipher(aesd_pkg::out_t plain);
        pending_plain.push_back(plain);
    endfunction

    // Compares one accepted result with the oldest expected plaintext.
    function void check_plain(aesd_pkg::out_t got);
        aesd_pkg::out_t want;
        if (pending_plain.size() == 0) begin
            $error("unexpected result: plain_high %h plain_low %h",
                   got.plain_high, got.plain_low);
            errors++;
            return;
        end
        want = pending_plain.pop_front();
        checked++;
        if (got.plain_high !== want.plain_high) begin
            $error("plain_high: expected %h actual %h", want.plain_high, got.plain_high);
            errors++;
        end
        if (got.plain_low !== want.plain_low) begin
            $error("plain_low: expected %h actual %h", want.plain_low, got.plain_low);
            errors++;
        end
    endfunction
endclass

module aes_block_decrypt_unit_test;
    import aesd_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;

    plaintext_scoreboard board;

    // Predictor copy of the registers and the key schedule.
    logic [1:0]  model_key_size;
    logic [63:0] model_key [4];
    logic [31:0] model_sched [60];
    bit          model_sched_fresh;
    int          model_rounds;
    int          sent_items;
    int          sizes_seen [3];

    aes_block_decrypt_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #10 aclk = ~aclk;

    // GF(2^8) multiply, written bit serially.
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Forward S-box entry, found by searching the inverse table.
    function automatic logic [7:0] fwd_sbox(logic [7:0] v);
        for (int k = 0; k < 256; k++)
            if (INV_SBOX[k] == v) return k[7:0];
        return 8'h00;
    endfunction

    function automatic logic [31:0] fwd_word(logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    // Expands the current key into the schedule; key size three acts as 256 bits.
    task automatic expand_schedule();
        int nk;
        int total;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = (model_key_size >= 2) ? 8 : (model_key_size == 1 ? 6 : 4);
        model_rounds = nk + 6;
        total = 4 * (model_rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < total; i++) begin
            if (i < nk) begin
                model_sched[i] = i[0] ? model_key[i >> 1][31:0] : model_key[i >> 1][63:32];
            end else begin
                t = model_sched[i - 1];
                if (i % nk == 0) begin
                    t = fwd_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
                end else if (nk > 6 && i % nk == 4) begin
                    t = fwd_word(t);
                end
                model_sched[i] = model_sched[i - nk] ^ t;
            end
        end
        model_sched_fresh = 1;
    endtask

    // Decrypts one block with the predictor's schedule.
    task automatic decrypt_block(input in_t blk, output out_t plain);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] flat;
        if (!model_sched_fresh) expand_schedule();
        flat = {blk.cipher_high, blk.cipher_low};
        for (int k = 0; k < 16; k++) st[k] = flat[127 - 8*k -: 8];
        for (int rnd = model_rounds; rnd >= 0; rnd--) begin
            if (rnd != model_rounds) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4*((c + r) % 4) + r] = INV_SBOX[st[4*c + r]];
                st = tmp;
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4*c + r] ^= model_sched[4*rnd + c][31 - 8*r -: 8];
            if (rnd != model_rounds && rnd != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = gf_mul(a0,8'h0e)^gf_mul(a1,8'h0b)^gf_mul(a2,8'h0d)^gf_mul(a3,8'h09);
                    st[4*c+1] = gf_mul(a0,8'h09)^gf_mul(a1,8'h0e)^gf_mul(a2,8'h0b)^gf_mul(a3,8'h0d);
                    st[4*c+2] = gf_mul(a0,8'h0d)^gf_mul(a1,8'h09)^gf_mul(a2,8'h0e)^gf_mul(a3,8'h0b);
                    st[4*c+3] = gf_mul(a0,8'h0b)^gf_mul(a1,8'h0d)^gf_mul(a2,8'h09)^gf_mul(a3,8'h0e);
                end
            end
        end
        for (int k = 0; k < 16; k++) flat[127 - 8*k -: 8] = st[k];
        plain.plain_high = flat[127:64];
        plain.plain_low  = flat[63:0];
    endtask

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Writes one register and mirrors it into the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_SIZE:   model_key_size = value[1:0];
            CFG_KEY_WORD_0: model_key[0] = value;
            CFG_KEY_WORD_1: model_key[1] = value;
            CFG_KEY_WORD_2: model_key[2] = value;
            CFG_KEY_WORD_3: model_key[3] = value;
            default: ;
        endcase
        if (idx <= CFG_KEY_WORD_3) model_sched_fresh = 0;
    endtask

    task automatic load_key(input logic [1:0] ksize, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(CFG_KEY_SIZE, {62'h0, ksize});
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
    endtask

    // Presents one ciphertext item and holds it until accepted. Valid drops only for a gap,
    // so an item that follows with no gap replaces the last one at the same falling edge.
    task automatic send_cipher(input logic [63:0] hi, input logic [63:0] lo);
        in_t  blk;
        out_t plain;
        int   n_gap;
        blk.cipher_high = hi;
        blk.cipher_low  = lo;
        n_gap = gap_len();
        if (n_gap > 0) begin
            s_valid <= 1'b0;
            repeat (n_gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= blk;
        do @(posedge aclk); while (!s_ready);
        decrypt_block(blk, plain);
        board.note_cipher(plain);
        sent_items++;
        sizes_seen[model_rounds == 10 ? 0 : (model_rounds == 12 ? 1 : 2)]++;
        @(negedge aclk);
    endtask

    // Drops the input and waits until every expected result has come.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending_plain.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return {64{1'b1}};
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h0000_0000_0000_0001;
            default: return rand64();
        endcase
    endfunction

    // Result side: random stalls, checks each accepted item.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < 70) m_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 50)) @(negedge aclk);
            end else m_ready <= 1'b0;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) board.check_plain(m_payload);

    // Run limit.
    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_SIZE;
        cfg_wdata = 64'h0;
        s_valid = 1'b0;
        s_payload = '0;
        board = new();
        model_key_size = 2'd0;
        for (int k = 0; k < 4; k++) model_key[k] = 64'h0;
        model_sched_fresh = 0;
        model_rounds = 10;
        sent_items = 0;
        sizes_seen = '{0, 0, 0};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset key: all zeros, 128 bits.
        send_cipher(64'h0, 64'h0);
        send_cipher({64{1'b1}}, {64{1'b1}});
        wait_drained();

        // FIPS-197 appendix C vectors for each key size.
        load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        send_cipher(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_cipher(64'h8000000000000000, 64'h0000000000000001);
        wait_drained();
        load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h0);
        send_cipher(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        wait_drained();
        load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_cipher(64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_cipher(64'h0, {64{1'b1}});
        wait_drained();
        // Key size three behaves as 256 bits; all-ones key.
        load_key(2'd3, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        send_cipher({64{1'b1}}, 64'h0);
        wait_drained();
        // Rewriting the key size to two, which still selects 256 bits, and an out-of-range index that is ignored.
        write_reg(CFG_KEY_SIZE, 64'h2);
        write_reg(3'd7, rand64());
        send_cipher(64'h0123456789abcdef, 64'hfedcba9876543210);
        // Sender pauses until everything has come back.
        wait_drained();

        // Random phases: new key and size, then a run of random blocks.
        while (sent_items < 1400) begin
            load_key($urandom_range(0, 3), edge_value(), edge_value(), edge_value(), edge_value());
            repeat ($urandom_range(5, 120)) begin
                if ($urandom_range(0, 9) == 0) send_cipher(edge_value(), edge_value());
                else send_cipher(rand64(), rand64());
            end
            wait_drained();
        end

        $display("Decrypted %0d blocks: %0d with 128-bit, %0d with 192-bit, %0d with 256-bit keys.",
                 sent_items, sizes_seen[0], sizes_seen[1], sizes_seen[2]);
        $display("Checked %0d results across many key reloads under random stalls.",
                 board.checked);
        if (board.errors == 0 && board.pending_plain.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/aesd_pkg.sv
rtl/core/aesd_ram.sv
rtl/core/aesd_keyexp.sv
rtl/core/aesd_round.sv
rtl/core/aes_block_decrypt_unit.sv
dv/aes_block_decrypt_unit_test.sv
